// ===== design/sse_pkg.sv =====
package sse_pkg;

  localparam int unsigned CapacityDefault   = 64;
  localparam int unsigned ValueWidthDefault = 32;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_ERASE  = 3'd1,
    OP_FIND   = 3'd2,
    OP_READ   = 3'd3,
    OP_CLEAR  = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_APPLY = 1'b1
  } state_e;

  typedef enum logic [1:0] {
    CM_HOLD   = 2'd0,
    CM_INSERT = 2'd1,
    CM_DELETE = 2'd2
  } cell_mode_e;

  typedef struct packed {
    logic        flag_en;
    cell_mode_e  mode;
  } cell_ctrl_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] key_value;
    logic [5:0]         read_index;
  } in_beat_t;

  typedef struct packed {
    logic               found;
    logic [6:0]         position;
    logic [6:0]         entry_count;
    logic signed [31:0] read_value;
    logic [1:0]         status;
  } out_beat_t;

endpackage

// ===== design/sse_cell.sv =====
module sse_cell #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                    clk_i,
  input  sse_pkg::cell_ctrl_t     ctrl_i,
  input  logic                    valid_i,
  input  logic [VALUE_WIDTH-1:0]  key_i,
  input  logic                    left_lt_i,
  input  logic [VALUE_WIDTH-1:0]  left_val_i,
  input  logic [VALUE_WIDTH-1:0]  right_val_i,
  output logic [VALUE_WIDTH-1:0]  val_o,
  output logic                    lt_o,
  output logic                    eq_o
);
  import sse_pkg::*;

  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic                   lt_q, eq_q;

  // Compare own entry with the key when a beat comes in
  always_ff @(posedge clk_i) begin
    if (ctrl_i.flag_en) begin
      lt_q <= valid_i && ($signed(val_q) < $signed(key_i));
      eq_q <= valid_i && (val_q == key_i);
    end
  end

  // Open a slot at the lower bound, or close the gap left by an erase
  always_comb begin
    val_d = val_q;
    case (ctrl_i.mode)
      CM_INSERT: begin
        if (!lt_q) val_d = left_lt_i ? key_i : left_val_i;
      end
      CM_DELETE: begin
        if (!lt_q) val_d = right_val_i;
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;

endmodule

// ===== design/sse_reduce.sv =====
module sse_reduce #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned CW          = 7
) (
  input  logic [CAPACITY-1:0]    lt_i,
  input  logic [CAPACITY-1:0]    eq_i,
  input  logic [VALUE_WIDTH-1:0] vals_i [CAPACITY],
  input  logic [5:0]             read_index_i,
  input  logic [CW-1:0]          count_i,
  output logic                   found_o,
  output logic [CW-1:0]          lb_o,
  output logic                   rd_ok_o,
  output logic [31:0]            rd_value_o
);
  import sse_pkg::*;

  logic [CAPACITY-1:0]    bnd;
  logic [VALUE_WIDTH-1:0] rsel;
  logic [63:0]            rext;

  // Boundary of the thermometer of less-than flags marks the lower bound
  always_comb begin
    bnd[0] = !lt_i[0];
    for (int i = 1; i < CAPACITY; i++) begin
      bnd[i] = lt_i[i-1] && !lt_i[i];
    end
  end

  // Encode lower bound; all entries below the key puts it past the last cell
  always_comb begin
    lb_o = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (bnd[i]) lb_o = lb_o | CW'(i);
    end
    if (lt_i[CAPACITY-1]) lb_o = CW'(CAPACITY);
  end

  assign found_o = |eq_i;

  // Select the entry at the read index
  always_comb begin
    rsel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (int'(read_index_i) == i) rsel = rsel | vals_i[i];
    end
  end

  assign rext       = 64'($signed(rsel));
  assign rd_value_o = rext[31:0];
  assign rd_ok_o    = int'(read_index_i) < int'(count_i);

endmodule

// ===== design/sorted_set_engine_core.sv =====
// Channel | Direction | Handshake              | Beat
// in      | input     | in_valid_i / in_stall_o   | sse_pkg::in_beat_t
// out     | output    | out_valid_o / out_stall_i | sse_pkg::out_beat_t
//
// Each beat has every cell compare its entry with the key when it is accepted;
// then, in the apply state, the cells shift in step with their neighbors and
// the result is written to the output register.
// A result waiting in the output register holds the next beat in the apply
// cycle; the input is free again as soon as the result register is loaded.
// Reset clears the entry count and the control state; entries are not cleared.
module sorted_set_engine_core #(
  parameter int unsigned CAPACITY    = sse_pkg::CapacityDefault,
  parameter int unsigned VALUE_WIDTH = sse_pkg::ValueWidthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sse_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sse_pkg::out_beat_t out_beat_o
);
  import sse_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e                 state_q, state_d;
  in_beat_t               op_q;
  logic [CW-1:0]          count_q, count_d;
  logic                   out_valid_q, out_valid_d;
  out_beat_t              out_beat_q, out_beat_d;
  logic                   accept, fire;
  logic [63:0]            in_key_ext, op_key_ext;
  logic [VALUE_WIDTH-1:0] key_w;
  cell_ctrl_t             ctrl;
  logic                   ins_do, del_do;

  logic [CAPACITY-1:0]    lt, eq, valid;
  logic [VALUE_WIDTH-1:0] vals [CAPACITY];
  logic                   present, rd_ok;
  logic [CW-1:0]          lb;
  logic [31:0]            rd_value;

  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign fire   = (state_q == ST_APPLY) && (!out_valid_q || !out_stall_i);

  // Zero-extend the key and take its low VALUE_WIDTH bits as a two's complement number
  assign in_key_ext = {32'd0, in_beat_i.key_value};
  assign op_key_ext = {32'd0, op_q.key_value};
  assign key_w = (state_q == ST_IDLE) ? in_key_ext[VALUE_WIDTH-1:0]
                                      : op_key_ext[VALUE_WIDTH-1:0];

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_APPLY;
      ST_APPLY: if (fire) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // Hold the accepted beat
  always_ff @(posedge clk_i) begin
    if (accept) op_q <= in_beat_i;
  end

  // Decide the shift for this beat
  assign ins_do = (op_q.opcode == OP_INSERT) && !present && (count_q < CW'(CAPACITY));
  assign del_do = (op_q.opcode == OP_ERASE) && present;

  always_comb begin
    ctrl.flag_en = accept;
    ctrl.mode    = CM_HOLD;
    if (fire && ins_do) ctrl.mode = CM_INSERT;
    if (fire && del_do) ctrl.mode = CM_DELETE;
  end

  // Row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign valid[i] = CW'(i) < count_q;
    sse_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .valid_i     (valid[i]),
      .key_i       (key_w),
      .left_lt_i   ((i == 0) ? 1'b1 : lt[(i == 0) ? 0 : i-1]),
      .left_val_i  (vals[(i == 0) ? 0 : i-1]),
      .right_val_i (vals[(i == CAPACITY-1) ? i : i+1]),
      .val_o       (vals[i]),
      .lt_o        (lt[i]),
      .eq_o        (eq[i])
    );
  end

  sse_reduce #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH),
    .CW          (CW)
  ) u_reduce (
    .lt_i         (lt),
    .eq_i         (eq),
    .vals_i       (vals),
    .read_index_i (op_q.read_index),
    .count_i      (count_q),
    .found_o      (present),
    .lb_o         (lb),
    .rd_ok_o      (rd_ok),
    .rd_value_o   (rd_value)
  );

  // Build the result and the new count
  always_comb begin
    count_d    = count_q;
    out_beat_d = '0;
    case (op_q.opcode)
      OP_INSERT, OP_ERASE, OP_FIND: begin
        out_beat_d.found    = present;
        out_beat_d.position = 7'(lb);
        if (ins_do) count_d = count_q + CW'(1);
        if (del_do) count_d = count_q - CW'(1);
        if ((op_q.opcode == OP_INSERT) && !present && !ins_do) begin
          out_beat_d.status = STAT_FULL;
        end
      end
      OP_READ: begin
        if (rd_ok) out_beat_d.read_value = rd_value;
        else       out_beat_d.status     = STAT_RANGE;
      end
      OP_CLEAR: count_d = '0;
      default:  count_d = count_q;
    endcase
    out_beat_d.entry_count = 7'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (fire) begin
      count_q <= count_d;
    end
  end

  // Output register
  assign out_valid_d = fire || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) out_beat_q <= out_beat_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

// ===== design/sse_checker.sv =====
module sse_checker #(
  parameter int unsigned CAPACITY = sse_pkg::CapacityDefault
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input sse_pkg::out_beat_t out_beat_o
);
  import sse_pkg::*;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("result beat changed while stalled");

  // Stall further input while a beat is in work
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepting a beat");

  // Out-of-range read reports no found flag, position or read value
  a_range_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_beat_o.status == STAT_RANGE) |->
      !out_beat_o.found && (out_beat_o.position == 7'd0) &&
      (out_beat_o.read_value == 32'sd0))
    else $error("out-of-range read carries data");

  // Dropped insert only when the store is full
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_beat_o.status == STAT_FULL) |->
      !out_beat_o.found && (out_beat_o.entry_count == 7'(CAPACITY)))
    else $error("insert dropped while store not full");

  // Count never exceeds capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (CAPACITY < 128) |-> (int'(out_beat_o.entry_count) <= CAPACITY))
    else $error("entry count above capacity");

endmodule

bind sorted_set_engine_core sse_checker #(
  .CAPACITY (CAPACITY)
) u_sse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_o  (out_beat_o)
);
